[rtl/core/md5sh_pkg.sv]
// md5sh_pkg: shared types, constants and round tables for the MD5 stream hasher.
// Used by md5sh_block_ram, md5sh_round and md5_stream_hash; depends on nothing.
`default_nettype none

package md5sh_pkg;

  // chaining values loaded at reset and after each digest
  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;

  localparam logic [7:0] PAD_MARK     = 8'h80;
  localparam logic [3:0] LEN_LO_WORD  = 4'd14;
  localparam logic [3:0] LEN_HI_WORD  = 4'd15;
  localparam logic [3:0] LAST_WORD    = 4'd15;
  localparam logic [5:0] LAST_ROUND   = 6'd63;
  localparam logic [5:0] LAST_BYTE    = 6'd63;
  localparam logic [2:0] DIGEST_WORDS = 3'd4;
  localparam logic [1:0] LAST_DIGEST  = 2'd3;

  // one write request into the block buffer
  typedef struct packed {
    logic        en;
    logic [3:0]  be;
    logic [3:0]  addr;
    logic [31:0] data;
  } blk_wr_t;

  // control of the round datapath
  typedef struct packed {
    logic       load;
    logic       step;
    logic [5:0] rnd;
  } round_ctrl_t;

  localparam logic [31:0] K_TABLE [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // rotate amounts, indexed by {stage, round[1:0]}
  localparam logic [4:0] SHIFT_TABLE [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  // message word used by a round
  function automatic logic [3:0] msg_index(input logic [5:0] rnd);
    logic [3:0] r;
    logic [3:0] g;
    r = rnd[3:0];
    unique case (rnd[5:4])
      2'd0:    g = r;
      2'd1:    g = 4'(r * 4'd5 + 4'd1);
      2'd2:    g = 4'(r * 4'd3 + 4'd5);
      default: g = 4'(r * 4'd7);
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

[rtl/core/md5sh_block_ram.sv]
// md5sh_block_ram: 16 x 32 block buffer with byte-lane writes and a registered read.
// Depends on md5sh_pkg for the write request type.
`default_nettype none

module md5sh_block_ram (
  input  wire logic             clk,
  input  wire md5sh_pkg::blk_wr_t wr,
  input  wire logic [3:0]       raddr,
  output logic      [31:0]      rdata
);

  logic [31:0] mem [16];

  // byte-lane write port
  always_ff @(posedge clk) begin
    for (int j = 0; j < 4; j++) begin
      if (wr.en && wr.be[j]) begin
        mem[wr.addr][8*j +: 8] <= wr.data[8*j +: 8];
      end
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/core/md5sh_round.sv]
// md5sh_round: working registers A..D and one MD5 round per step.
// Depends on md5sh_pkg for the round tables and control struct.
`default_nettype none

module md5sh_round (
  input  wire logic                   clk,
  input  wire md5sh_pkg::round_ctrl_t ctrl,
  input  wire logic [3:0][31:0]       init,
  input  wire logic [31:0]            msg,
  output logic      [3:0][31:0]       work
);

  logic [31:0] a, b, c, d, f, sum;
  logic [63:0] rot;
  logic [4:0]  sh;

  assign a = work[0];
  assign b = work[1];
  assign c = work[2];
  assign d = work[3];

  // round function per stage
  always_comb begin
    unique case (ctrl.rnd[5:4])
      2'd0:    f = (b & c) | (~b & d);
      2'd1:    f = (b & d) | (c & ~d);
      2'd2:    f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
  end

  assign sum = a + f + msg + md5sh_pkg::K_TABLE[ctrl.rnd];
  assign sh  = md5sh_pkg::SHIFT_TABLE[{ctrl.rnd[5:4], ctrl.rnd[1:0]}];
  assign rot = {sum, sum} << sh;

  // load from chaining words or rotate the registers by one round
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      work <= init;
    end else if (ctrl.step) begin
      work[0] <= d;
      work[1] <= rot[63:32] + b;
      work[2] <= b;
      work[3] <= c;
    end
  end

endmodule

`default_nettype wire

[rtl/core/md5_stream_hash.sv]
// md5_stream_hash: MD5 of a byte stream; sequencer, padding and digest output.
// Depends on md5sh_pkg, md5sh_block_ram and md5sh_round.
//
// Usage:
//   s_* carries one request per byte: tdata is the byte, tuser says a byte is
//   present, tlast closes the message. m_* returns the digest as four requests,
//   A first; tuser is the word index and tlast marks word D.
//   A plain byte leaves s_tready high. A byte that fills a 64-byte block
//   starts a compression: one fetch, 64 rounds (one per cycle, one buffer
//   read each) and one chaining update. A closing request adds a padding
//   sweep of up to 16 buffer words (one per cycle) and a compression, twice
//   when fewer than 9 bytes of the block are free, then loads the output buffer.
//   The digest drains one word per cycle while m_tready is high. Input is
//   taken again while the digest drains; a second digest waits in the
//   sequencer until the output buffer is empty, so a stalled receiver
//   eventually stalls s_tready.
//   Reset restores the initial chaining words and a zero byte count; the
//   block buffer needs no clearing since padding overwrites every byte read.
`default_nettype none

module md5_stream_hash (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tuser,   // [0] byte_present
  input  wire logic        s_tlast,   // last
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [31:0] m_tdata,   // [31:0] digest_word
  output logic      [1:0]  m_tuser,   // [1:0] word_index
  output logic             m_tlast    // last_word
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_FETCH = 6'b000010,
    ST_ROUND = 6'b000100,
    ST_ACCUM = 6'b001000,
    ST_PAD   = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  state_t                 state;
  logic [3:0][31:0]       chain;
  logic [3:0][31:0]       work;
  logic [31:0]            count;
  logic [31:0]            count_next;
  logic [5:0]             rnd;
  logic [3:0]             sweep;
  logic                   closing, marked, len_done, len_here;
  logic [3:0][31:0]       out_words;
  logic [2:0]             out_left;
  logic [1:0]             out_idx;
  logic                   s_fire, m_fire, byte_in;
  logic [31:0]            msg;
  logic [3:0]             raddr;
  logic [5:0]             rd_rnd;
  md5sh_pkg::blk_wr_t     wr;
  md5sh_pkg::round_ctrl_t rctl;
  logic                   mark_here;

  assign s_tready   = (state == ST_IDLE);
  assign s_fire     = s_tvalid && s_tready;
  assign m_fire     = m_tvalid && m_tready;
  assign byte_in    = s_fire && s_tuser;
  assign count_next = count + {31'd0, byte_in};

  assign m_tvalid = (out_left != 3'd0);
  assign m_tdata  = out_words[0];
  assign m_tuser  = out_idx;
  assign m_tlast  = (out_idx == md5sh_pkg::LAST_DIGEST);

  // buffer read: prefetch the message word of the next round
  assign rd_rnd = (state == ST_ROUND) ? rnd + 6'd1 : rnd;
  assign raddr  = md5sh_pkg::msg_index(rd_rnd);

  assign rctl.load = (state == ST_FETCH);
  assign rctl.step = (state == ST_ROUND);
  assign rctl.rnd  = rnd;

  assign mark_here = !marked && (sweep == count[5:2]);

  // buffer write: incoming byte or one padding word
  always_comb begin
    wr = '0;
    if (byte_in) begin
      wr.en   = 1'b1;
      wr.addr = count[5:2];
      wr.be   = 4'b0001 << count[1:0];
      wr.data = {4{s_tdata}};
    end else if (state == ST_PAD) begin
      wr.en   = 1'b1;
      wr.addr = sweep;
      wr.be   = 4'hf;
      if (len_here && sweep == md5sh_pkg::LEN_LO_WORD) begin
        wr.data = {count[28:0], 3'b000};
      end else if (len_here && sweep == md5sh_pkg::LEN_HI_WORD) begin
        wr.data = {29'd0, count[31:29]};
      end else if (mark_here) begin
        for (int j = 0; j < 4; j++) begin
          wr.be[j]         = (2'(j) >= count[1:0]);
          wr.data[8*j +: 8] = (2'(j) == count[1:0]) ? md5sh_pkg::PAD_MARK : 8'h00;
        end
      end
    end
  end

  md5sh_block_ram u_ram (
    .clk   (clk),
    .wr    (wr),
    .raddr (raddr),
    .rdata (msg)
  );

  md5sh_round u_round (
    .clk  (clk),
    .ctrl (rctl),
    .init (chain),
    .msg  (msg),
    .work (work)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      chain    <= {md5sh_pkg::INIT_D, md5sh_pkg::INIT_C,
                   md5sh_pkg::INIT_B, md5sh_pkg::INIT_A};
      count    <= '0;
      rnd      <= '0;
      sweep    <= '0;
      closing  <= 1'b0;
      marked   <= 1'b0;
      len_done <= 1'b0;
      len_here <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          count <= count_next;
          if (s_fire) begin
            closing <= s_tlast;
            if (byte_in && count[5:0] == md5sh_pkg::LAST_BYTE) begin
              state <= ST_FETCH;
            end else if (s_tlast) begin
              state    <= ST_PAD;
              sweep    <= count_next[5:2];
              len_here <= (count_next[5:3] != 3'b111);
            end
          end
        end
        ST_FETCH: begin
          rnd   <= '0;
          state <= ST_ROUND;
        end
        ST_ROUND: begin
          rnd <= rnd + 6'd1;
          if (rnd == md5sh_pkg::LAST_ROUND) begin
            state <= ST_ACCUM;
          end
        end
        ST_ACCUM: begin
          for (int k = 0; k < 4; k++) begin
            chain[k] <= chain[k] + work[k];
          end
          if (!closing) begin
            state <= ST_IDLE;
          end else if (len_done) begin
            state <= ST_EMIT;
          end else begin
            state    <= ST_PAD;
            sweep    <= marked ? 4'd0 : count[5:2];
            len_here <= marked || (count[5:3] != 3'b111);
          end
        end
        ST_PAD: begin
          sweep <= sweep + 4'd1;
          if (sweep == md5sh_pkg::LAST_WORD) begin
            marked   <= 1'b1;
            len_done <= len_here;
            state    <= ST_FETCH;
          end
        end
        ST_EMIT: begin
          if (out_left == 3'd0) begin
            chain    <= {md5sh_pkg::INIT_D, md5sh_pkg::INIT_C,
                         md5sh_pkg::INIT_B, md5sh_pkg::INIT_A};
            count    <= '0;
            closing  <= 1'b0;
            marked   <= 1'b0;
            len_done <= 1'b0;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // digest output buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_left <= '0;
      out_idx  <= '0;
    end else if (state == ST_EMIT && out_left == 3'd0) begin
      out_left <= md5sh_pkg::DIGEST_WORDS;
      out_idx  <= '0;
    end else if (m_fire) begin
      out_left <= out_left - 3'd1;
      out_idx  <= out_idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_left == 3'd0) begin
      out_words <= chain;
    end else if (m_fire) begin
      out_words <= {32'd0, out_words[3:1]};
    end
  end

`ifndef ASSERT_OFF
  // the block buffer is never written while a compression reads it
  a_no_write_in_rounds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FETCH || state == ST_ROUND) |-> !wr.en)
    else $error("block buffer written during compression");

  // output buffer never holds more than one digest
  a_out_bound: assert property (@(posedge clk) disable iff (rst)
    out_left <= md5sh_pkg::DIGEST_WORDS)
    else $error("output buffer overfilled");

  // the length words are only placed after the end mark
  a_len_after_mark: assert property (@(posedge clk) disable iff (rst)
    len_done |-> (marked && closing))
    else $error("length written before end mark");

  // a finished round sequence always leads to the chaining update
  a_rounds_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND && rnd == md5sh_pkg::LAST_ROUND) |=> state == ST_ACCUM)
    else $error("compression did not end in chaining update");

  // the word index and remaining count stay in step
  a_idx_sync: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ({1'b0, out_idx} + out_left == md5sh_pkg::DIGEST_WORDS))
    else $error("digest index out of step");
`endif

endmodule

`default_nettype wire

[sim/tb_md5_stream_hash.sv]
// tb_md5_stream_hash: self-checking testbench for the MD5 stream hasher.
// Depends only on the md5_stream_hash RTL; holds its own MD5 digest predictor.
`default_nettype none

module tb_md5_stream_hash;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned RANDOM_ITEMS = 480;
  localparam logic [7:0]  PAD_BYTE     = 8'h80;
  localparam logic [31:0] CHAIN_A0     = 32'h67452301;
  localparam logic [31:0] CHAIN_B0     = 32'hefcdab89;
  localparam logic [31:0] CHAIN_C0     = 32'h98badcfe;
  localparam logic [31:0] CHAIN_D0     = 32'h10325476;
  // MD5 of the empty string as words {D, C, B, A}
  localparam logic [127:0] EMPTY_DIGEST = 128'h7e42f8ec_980980e9_04b2008f_d98c1dd4;
  // rotate amounts, one byte each, indexed by {stage, round[1:0]}
  localparam logic [127:0] ROT_PACKED = 128'h150f0a06_17100b04_140e0905_16110c07;

  // receiver stall patterns
  localparam logic [1:0] RX_ALWAYS = 2'd0;
  localparam logic [1:0] RX_COIN   = 2'd1;
  localparam logic [1:0] RX_SPARSE = 2'd2;

  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  slot;
    logic        closing;
  } digest_word_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [7:0] data_byte
  logic        s_tuser;   // [0] byte_present
  logic        s_tlast;   // last
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // [31:0] digest_word
  logic [1:0]  m_tuser;   // [1:0] word_index
  logic        m_tlast;   // last_word

  // predictor state
  logic [31:0] md5_chain [4];
  logic [31:0] md5_block [16];
  logic [31:0] md5_count;
  logic [31:0] sine_const [64];

  digest_word_t digest_expect_q [$];
  digest_word_t digest_head;

  int unsigned error_count;
  int unsigned words_checked;
  int unsigned items_sent;
  int unsigned noise_sent;
  int unsigned digests_predicted;
  int unsigned cycle_count;
  int unsigned burst_left;
  bit          steady_send;
  logic [1:0]  rx_mode;
  int unsigned rx_phase_left;

  md5_stream_hash i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [31:0] rotl32(logic [31:0] v, int unsigned r);
    return (v << r) | (v >> (32 - r));
  endfunction

  function automatic void md5_restart();
    md5_chain[0] = CHAIN_A0;
    md5_chain[1] = CHAIN_B0;
    md5_chain[2] = CHAIN_C0;
    md5_chain[3] = CHAIN_D0;
    md5_block    = '{default: 32'h0};
    md5_count    = 32'h0;
  endfunction

  // 64 rounds over the current block, then fold into the chaining words
  function automatic void md5_compress();
    logic [31:0] a, b, c, d, f, t;
    int unsigned g, sh;
    a = md5_chain[0];
    b = md5_chain[1];
    c = md5_chain[2];
    d = md5_chain[3];
    for (int unsigned i = 0; i < 64; i++) begin
      case (i >> 4)
        0: begin
          f = (b & c) | (~b & d);
          g = i;
        end
        1: begin
          f = (b & d) | (c & ~d);
          g = 5 * i + 1;
        end
        2: begin
          f = b ^ c ^ d;
          g = 3 * i + 5;
        end
        default: begin
          f = c ^ (b | ~d);
          g = 7 * i;
        end
      endcase
      sh = {24'd0, ROT_PACKED[8 * ((i >> 4) * 4 + (i % 4)) +: 8]};
      t  = a + f + md5_block[g[3:0]] + sine_const[i[5:0]];
      a  = d;
      d  = c;
      c  = b;
      b  = b + rotl32(t, sh);
    end
    md5_chain[0] += a;
    md5_chain[1] += b;
    md5_chain[2] += c;
    md5_chain[3] += d;
  endfunction

  function automatic void md5_put_byte(int unsigned pos, logic [7:0] v);
    md5_block[pos[5:2]][(pos % 4) * 8 +: 8] = v;
  endfunction

  // update on one accepted request; a closing request queues four digest words
  function automatic void md5_absorb(logic [7:0] b, logic present, logic closing);
    int unsigned pos;
    digest_word_t w;
    if (present) begin
      pos = {26'd0, md5_count[5:0]};
      md5_put_byte(pos, b);
      md5_count++;
      if (pos == 63) md5_compress();
    end
    if (closing) begin
      pos = {26'd0, md5_count[5:0]};
      md5_put_byte(pos, PAD_BYTE);
      for (int unsigned p = pos + 1; p < 64; p++) md5_put_byte(p, 8'h00);
      // no room for the length: spill into one more block
      if (pos >= 56) begin
        md5_compress();
        md5_block = '{default: 32'h0};
      end
      md5_block[14] = md5_count << 3;
      md5_block[15] = md5_count >> 29;
      md5_compress();
      for (int unsigned k = 0; k < 4; k++) begin
        w.word    = md5_chain[k[1:0]];
        w.slot    = 2'(k);
        w.closing = (k == 3);
        digest_expect_q.push_back(w);
      end
      digests_predicted++;
      md5_restart();
    end
  endfunction

  function automatic void build_sine_table();
    real s;
    for (int i = 0; i < 64; i++) begin
      s = $sin(real'(i + 1));
      if (s < 0.0) s = -s;
      sine_const[i[5:0]] = 32'(longint'($floor(s * 4294967296.0)));
    end
  endfunction

  // ---------------------------------------------------------------- drivers

  // one request on the input side; sender runs in bursts with random gaps
  task automatic send_request(input logic [7:0] b, input logic present, input logic closing);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = steady_send ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= present;
    s_tlast  <= closing;
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    @(posedge clk);
    md5_absorb(b, present, closing);
    burst_left--;
    if (present || closing) items_sent++;
    else noise_sent++;
  endtask

  // hold off the sender until every predicted digest word has come out
  task automatic wait_digests_drained();
    s_tvalid <= 1'b0;
    burst_left = 0;
    @(negedge clk);
    while (digest_expect_q.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // receiver stall pattern, switched at random among the three modes
  always @(posedge clk) begin
    if (rx_phase_left == 0) begin
      rx_mode       <= 2'($urandom_range(0, 2));
      rx_phase_left <= $urandom_range(20, 200);
    end else begin
      rx_phase_left <= rx_phase_left - 1;
    end
    case (rx_mode)
      RX_ALWAYS: m_tready <= 1'b1;
      RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: m_tready <= ($urandom_range(0, 15) == 0);
      default:   m_tready <= 1'b1;
    endcase
  end

  // ---------------------------------------------------------------- checker

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (digest_expect_q.size() == 0) begin
        $display("%0t ns: digest word with none expected: expected none, actual %h slot %0d",
                 $time, m_tdata, m_tuser);
        error_count++;
      end else begin
        digest_head = digest_expect_q.pop_front();
        words_checked++;
        if (m_tdata !== digest_head.word) begin
          $display("%0t ns: digest_word expected %h actual %h", $time, digest_head.word,
                   m_tdata);
          error_count++;
        end
        if (m_tuser !== digest_head.slot) begin
          $display("%0t ns: word_index expected %0d actual %0d", $time, digest_head.slot,
                   m_tuser);
          error_count++;
        end
        if (m_tlast !== digest_head.closing) begin
          $display("%0t ns: last_word expected %0b actual %0b", $time, digest_head.closing,
                   m_tlast);
          error_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t ns: timeout, %0d digest words still expected", $time,
               digest_expect_q.size());
      $display("FAIL md5_stream_hash");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests

  // empty message, "abc", a one-byte message, ignored requests, bare end marker
  task automatic test_short_messages();
    send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    // the predictor must agree with the known digest of the empty string
    if ({digest_expect_q[3].word, digest_expect_q[2].word, digest_expect_q[1].word,
         digest_expect_q[0].word} !== EMPTY_DIGEST) begin
      $display("%0t ns: empty-string digest expected %h actual %h", $time, EMPTY_DIGEST,
               {digest_expect_q[3].word, digest_expect_q[2].word, digest_expect_q[1].word,
                digest_expect_q[0].word});
      error_count++;
    end
    send_request(8'h61, 1'b1, 1'b0);
    send_request(8'h62, 1'b1, 1'b0);
    send_request(8'h63, 1'b1, 1'b1);
    send_request(8'h00, 1'b1, 1'b1);
    send_request(8'hff, 1'b0, 1'b0);
    send_request(8'hff, 1'b1, 1'b0);
    send_request(8'h00, 1'b0, 1'b0);
    send_request(8'ha5, 1'b1, 1'b0);
    send_request(8'h5a, 1'b0, 1'b1);
    wait_digests_drained();
  endtask

  // closing requests sent back to back with no sender gaps
  task automatic test_back_to_back_digests();
    steady_send = 1'b1;
    repeat (3) send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    send_request(8'hff, 1'b1, 1'b1);
    send_request(8'h01, 1'b1, 1'b1);
    send_request(8'h80, 1'b1, 1'b0);
    send_request(8'h7f, 1'b1, 1'b1);
    send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    steady_send = 1'b0;
    wait_digests_drained();
  endtask

  // random messages: mostly short, some around the 56- and 64-byte boundaries
  task automatic test_random_messages(input int unsigned item_goal);
    int unsigned len, start;
    bit on_byte;
    start = items_sent;
    while (items_sent - start < item_goal) begin
      if ($urandom_range(0, 3) == 0)
        len = 64 * $urandom_range(0, 1) + 55 + $urandom_range(0, 10);
      else
        len = $urandom_range(0, 20);
      on_byte     = (len != 0) && ($urandom_range(0, 1) == 1);
      steady_send = ($urandom_range(0, 3) == 0);
      for (int unsigned i = 0; i < len; i++) begin
        if ($urandom_range(0, 19) == 0)
          send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        send_request(8'($urandom_range(0, 255)), 1'b1, on_byte && (i == len - 1));
      end
      if (!on_byte) send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      if ($urandom_range(0, 5) == 0) wait_digests_drained();
    end
    steady_send = 1'b0;
  endtask

  initial begin
    clk               = 1'b0;
    rst               = 1'b1;
    s_tvalid          = 1'b0;
    s_tdata           = 8'h00;
    s_tuser           = 1'b0;
    s_tlast           = 1'b0;
    m_tready          = 1'b0;
    rx_mode           = RX_ALWAYS;
    rx_phase_left     = 0;
    error_count       = 0;
    words_checked     = 0;
    items_sent        = 0;
    noise_sent        = 0;
    digests_predicted = 0;
    cycle_count       = 0;
    burst_left        = 0;
    steady_send       = 1'b0;
    build_sine_table();
    md5_restart();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_short_messages();
    test_back_to_back_digests();
    test_random_messages(RANDOM_ITEMS);

    wait_digests_drained();
    repeat (40) @(posedge clk);
    $display("Run covered %0d messages from %0d byte/end requests (%0d ignored requests),",
             digests_predicted, items_sent, noise_sent);
    $display("with %0d digest words checked under random sender gaps and receiver stalls.",
             words_checked);
    if (error_count == 0) begin
      $display("PASS md5_stream_hash");
    end else begin
      $display("FAIL md5_stream_hash");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
rtl/core/md5sh_pkg.sv
rtl/core/md5sh_block_ram.sv
rtl/core/md5sh_round.sv
rtl/core/md5_stream_hash.sv
sim/tb_md5_stream_hash.sv
